// ===== src/bmpr_pkg.sv =====
package bmpr_pkg;

   typedef enum logic [1:0] {
      ROLE_INIT  = 2'd0,
      ROLE_GM    = 2'd1,
      ROLE_SLAVE = 2'd2
   } role_type;

   localparam logic [1:0] EV_ENABLE   = 2'd0;
   localparam logic [1:0] EV_ANNOUNCE = 2'd1;
   localparam logic [1:0] EV_TICK     = 2'd2;

   localparam logic [2:0] CSR_PRIORITY1    = 3'd0;
   localparam logic [2:0] CSR_CLOCK_CLASS  = 3'd1;
   localparam logic [2:0] CSR_ACCURACY     = 3'd2;
   localparam logic [2:0] CSR_LOG_VARIANCE = 3'd3;
   localparam logic [2:0] CSR_PRIORITY2    = 3'd4;
   localparam logic [2:0] CSR_IDENTITY     = 3'd5;
   localparam logic [2:0] CSR_INTERVAL     = 3'd6;
   localparam logic [2:0] CSR_TIMEOUT      = 3'd7;

   localparam logic [15:0] OWN_STEPS_REMOVED = 16'd0;
   localparam logic [7:0]  OWN_CLOCK_SOURCE  = 8'd160;

   // field order is compare order: the packed word compares lexicographically
   typedef struct packed {
      logic [7:0]  priority1;
      logic [7:0]  clock_class;
      logic [7:0]  clock_accuracy;
      logic [15:0] log_variance;
      logic [7:0]  priority2;
      logic [15:0] steps_removed;
      logic [7:0]  clock_source;
      logic [63:0] identity;
   } prio_vec_type;

endpackage

// ===== src/best_master_port_role_machine.sv =====
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | event_kind, rx_* announce vector
// rsp     | out       | rsp_valid/rsp_stall  | port_role, send_announce, sequence,
//         |           |                      | better_found, gm_* kept vector
// csr     | in        | csr_we               | csr_index, csr_wdata
// One word per cycle while req_stall is low; each result appears in the cycle after its request word is
// taken, held in the single result register behind the role, counter and vector compare logic.
// Reset is synchronous: role init, counters zero, kept vector zero, registers defaulted.
// req_stall is high only while a result is held and rsp_stall is high.
module best_master_port_role_machine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_event_kind,
   input  logic [7:0]  req_rx_priority1,
   input  logic [7:0]  req_rx_clock_class,
   input  logic [7:0]  req_rx_clock_accuracy,
   input  logic [15:0] req_rx_log_variance,
   input  logic [7:0]  req_rx_priority2,
   input  logic [15:0] req_rx_steps_removed,
   input  logic [7:0]  req_rx_clock_source,
   input  logic [63:0] req_rx_identity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_port_role,
   output logic        rsp_send_announce,
   output logic [15:0] rsp_announce_sequence,
   output logic        rsp_better_found,
   output logic [7:0]  rsp_gm_priority1,
   output logic [7:0]  rsp_gm_clock_class,
   output logic [7:0]  rsp_gm_clock_accuracy,
   output logic [15:0] rsp_gm_log_variance,
   output logic [7:0]  rsp_gm_priority2,
   output logic [15:0] rsp_gm_steps_removed,
   output logic [7:0]  rsp_gm_clock_source,
   output logic [63:0] rsp_gm_identity,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [7:0]  own_priority1_ff;
   logic [7:0]  own_clock_class_ff;
   logic [7:0]  own_clock_accuracy_ff;
   logic [15:0] own_log_variance_ff;
   logic [7:0]  own_priority2_ff;
   logic [63:0] own_identity_ff;
   logic [15:0] interval_ff;
   logic [15:0] timeout_ff;

   bmpr_pkg::role_type     role_ff, role_in;
   logic [15:0]            tick_ff, tick_in;
   logic [15:0]            seq_ff, seq_in;
   bmpr_pkg::prio_vec_type gm_ff, gm_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        send_ff, send_in;
   logic [15:0] seq_out_ff, seq_out_in;
   logic        better_ff, better_in;

   logic                   req_accept;
   bmpr_pkg::prio_vec_type rx_vec, loc_vec;
   logic                   rx_better;
   logic [15:0]            limit, limit_eff;
   logic [16:0]            tick_next;
   logic                   tick_hit;
   logic                   ev_enable, ev_announce, ev_tick;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign ev_enable   = req_accept & (req_event_kind == bmpr_pkg::EV_ENABLE);
   assign ev_announce = req_accept & (req_event_kind == bmpr_pkg::EV_ANNOUNCE);
   assign ev_tick     = req_accept & (req_event_kind == bmpr_pkg::EV_TICK);

   assign rx_vec = '{priority1: req_rx_priority1, clock_class: req_rx_clock_class,
                     clock_accuracy: req_rx_clock_accuracy,
                     log_variance: req_rx_log_variance, priority2: req_rx_priority2,
                     steps_removed: req_rx_steps_removed,
                     clock_source: req_rx_clock_source, identity: req_rx_identity};
   assign loc_vec = '{priority1: own_priority1_ff, clock_class: own_clock_class_ff,
                      clock_accuracy: own_clock_accuracy_ff,
                      log_variance: own_log_variance_ff, priority2: own_priority2_ff,
                      steps_removed: bmpr_pkg::OWN_STEPS_REMOVED,
                      clock_source: bmpr_pkg::OWN_CLOCK_SOURCE,
                      identity: own_identity_ff};

   assign rx_better = rx_vec < loc_vec;

   // zero limit acts as one
   assign limit     = (role_ff == bmpr_pkg::ROLE_GM) ? interval_ff : timeout_ff;
   assign limit_eff = (limit == 16'd0) ? 16'd1 : limit;
   assign tick_next = {1'b0, tick_ff} + 17'd1;
   assign tick_hit  = tick_next >= {1'b0, limit_eff};

   // next role
   always_comb begin
      role_in = role_ff;
      unique case (role_ff)
         bmpr_pkg::ROLE_INIT: begin
            if (ev_enable) role_in = bmpr_pkg::ROLE_GM;
         end
         bmpr_pkg::ROLE_GM: begin
            if (ev_announce && rx_better) role_in = bmpr_pkg::ROLE_SLAVE;
         end
         bmpr_pkg::ROLE_SLAVE: begin
            if (ev_tick && tick_hit) role_in = bmpr_pkg::ROLE_GM;
         end
         default: role_in = role_ff;
      endcase
   end

   // counters, kept vector and result word
   always_comb begin
      tick_in    = tick_ff;
      seq_in     = seq_ff;
      gm_in      = gm_ff;
      send_in    = 1'b0;
      seq_out_in = 16'd0;
      better_in  = 1'b0;
      unique case (role_ff)
         bmpr_pkg::ROLE_INIT: begin
            if (ev_enable) begin
               tick_in = 16'd0;
               gm_in   = loc_vec;
            end
         end
         bmpr_pkg::ROLE_GM, bmpr_pkg::ROLE_SLAVE: begin
            if (ev_announce) begin
               better_in = rx_better;
               gm_in     = rx_better ? rx_vec : loc_vec;
               if (rx_better) tick_in = 16'd0;
            end else if (ev_tick) begin
               if (tick_hit) begin
                  tick_in = 16'd0;
                  if (role_ff == bmpr_pkg::ROLE_GM) begin
                     send_in    = 1'b1;
                     seq_out_in = seq_ff;
                     seq_in     = seq_ff + 16'd1;
                  end
               end else begin
                  tick_in = tick_next[15:0];
               end
            end
         end
         default: tick_in = tick_ff;
      endcase
   end

   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         own_priority1_ff      <= 8'd246;
         own_clock_class_ff    <= 8'd248;
         own_clock_accuracy_ff <= 8'd254;
         own_log_variance_ff   <= 16'd16640;
         own_priority2_ff      <= 8'd248;
         own_identity_ff       <= 64'd0;
         interval_ff           <= 16'd1000;
         timeout_ff            <= 16'd3000;
      end else if (csr_we) begin
         unique case (csr_index)
            bmpr_pkg::CSR_PRIORITY1:    own_priority1_ff      <= csr_wdata[7:0];
            bmpr_pkg::CSR_CLOCK_CLASS:  own_clock_class_ff    <= csr_wdata[7:0];
            bmpr_pkg::CSR_ACCURACY:     own_clock_accuracy_ff <= csr_wdata[7:0];
            bmpr_pkg::CSR_LOG_VARIANCE: own_log_variance_ff   <= csr_wdata[15:0];
            bmpr_pkg::CSR_PRIORITY2:    own_priority2_ff      <= csr_wdata[7:0];
            bmpr_pkg::CSR_IDENTITY:     own_identity_ff       <= csr_wdata;
            bmpr_pkg::CSR_INTERVAL:     interval_ff           <= csr_wdata[15:0];
            bmpr_pkg::CSR_TIMEOUT:      timeout_ff            <= csr_wdata[15:0];
            default:                    interval_ff           <= interval_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff      <= bmpr_pkg::ROLE_INIT;
         tick_ff      <= 16'd0;
         seq_ff       <= 16'd0;
         gm_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         role_ff      <= role_in;
         tick_ff      <= tick_in;
         seq_ff       <= seq_in;
         gm_ff        <= gm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         send_ff    <= send_in;
         seq_out_ff <= seq_out_in;
         better_ff  <= better_in;
      end
   end

   // role and kept vector only move on an accepted word, so they track the held result
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_port_role         = role_ff;
   assign rsp_send_announce     = send_ff;
   assign rsp_announce_sequence = seq_out_ff;
   assign rsp_better_found      = better_ff;
   assign rsp_gm_priority1      = gm_ff.priority1;
   assign rsp_gm_clock_class    = gm_ff.clock_class;
   assign rsp_gm_clock_accuracy = gm_ff.clock_accuracy;
   assign rsp_gm_log_variance   = gm_ff.log_variance;
   assign rsp_gm_priority2      = gm_ff.priority2;
   assign rsp_gm_steps_removed  = gm_ff.steps_removed;
   assign rsp_gm_clock_source   = gm_ff.clock_source;
   assign rsp_gm_identity       = gm_ff.identity;

endmodule

// ===== src/bmpr_checker.sv =====
module bmpr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_port_role,
   input logic        rsp_send_announce,
   input logic [15:0] rsp_announce_sequence,
   input logic        rsp_better_found
);

   // announces go out only as grandmaster
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_announce |-> rsp_port_role == bmpr_pkg::ROLE_GM)
      else $error("announce sent outside grandmaster role");

   // a better announce always leaves the port slave
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_better_found |-> rsp_port_role == bmpr_pkg::ROLE_SLAVE)
      else $error("better announce without slave role");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_announce |-> rsp_announce_sequence == 16'd0)
      else $error("sequence nonzero without announce");

   // every taken request word yields a result word next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted word produced no result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_announce_sequence))
      else $error("stalled result word changed");

endmodule

bind best_master_port_role_machine bmpr_checker u_bmpr_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_port_role         (rsp_port_role),
   .rsp_send_announce     (rsp_send_announce),
   .rsp_announce_sequence (rsp_announce_sequence),
   .rsp_better_found      (rsp_better_found)
);

// ===== test/best_master_port_role_machine_tb.sv =====
module best_master_port_role_machine_tb;

   localparam logic [1:0] EV_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]             kind;
      bmpr_pkg::prio_vec_type rx;
   } port_event_type;

   typedef struct packed {
      bmpr_pkg::role_type     role;
      logic                   send;
      logic [15:0]            seq;
      logic                   better;
      bmpr_pkg::prio_vec_type gm;
   } port_status_type;

   typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type       what;
      port_event_type     ev;
      logic [2:0]         index;
      logic [63:0]        data;
      bit                 typed;
      bmpr_pkg::role_type role;
      logic               send;
      logic [15:0]        seq;
      logic               better;
   } script_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_event_kind;
   logic [7:0]  req_rx_priority1;
   logic [7:0]  req_rx_clock_class;
   logic [7:0]  req_rx_clock_accuracy;
   logic [15:0] req_rx_log_variance;
   logic [7:0]  req_rx_priority2;
   logic [15:0] req_rx_steps_removed;
   logic [7:0]  req_rx_clock_source;
   logic [63:0] req_rx_identity;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_port_role;
   logic        rsp_send_announce;
   logic [15:0] rsp_announce_sequence;
   logic        rsp_better_found;
   logic [7:0]  rsp_gm_priority1;
   logic [7:0]  rsp_gm_clock_class;
   logic [7:0]  rsp_gm_clock_accuracy;
   logic [15:0] rsp_gm_log_variance;
   logic [7:0]  rsp_gm_priority2;
   logic [15:0] rsp_gm_steps_removed;
   logic [7:0]  rsp_gm_clock_source;
   logic [63:0] rsp_gm_identity;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   // local copy of the settings
   logic [7:0]   own_p1, own_class, own_acc, own_p2;
   logic [15:0]  own_var;
   logic [63:0]  own_id;
   logic [15:0]  interval_ticks, timeout_ticks;

   // predicted port state
   bmpr_pkg::role_type     role_now;
   logic [15:0]            tick_count;
   logic [15:0]            seq_count;
   bmpr_pkg::prio_vec_type kept_gm;

   port_status_type pending_status[$];
   port_status_type oldest;
   script_row_type  script[$];
   int              fail_count;
   int              results_seen;
   bit              no_idle;

   best_master_port_role_machine DUT (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2400000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic bmpr_pkg::prio_vec_type own_vector();
      bmpr_pkg::prio_vec_type v;
      v.priority1      = own_p1;
      v.clock_class    = own_class;
      v.clock_accuracy = own_acc;
      v.log_variance   = own_var;
      v.priority2      = own_p2;
      v.steps_removed  = bmpr_pkg::OWN_STEPS_REMOVED;
      v.clock_source   = bmpr_pkg::OWN_CLOCK_SOURCE;
      v.identity       = own_id;
      return v;
   endfunction

   // zero limit behaves as one
   function automatic bit count_tick(logic [15:0] limit);
      logic [16:0] nxt;
      logic [15:0] lim;
      nxt = {1'b0, tick_count} + 17'd1;
      lim = (limit == 16'd0) ? 16'd1 : limit;
      if (nxt >= {1'b0, lim}) begin
         tick_count = '0;
         return 1'b1;
      end
      tick_count = nxt[15:0];
      return 1'b0;
   endfunction

   function automatic port_status_type next_port_status(port_event_type ev);
      port_status_type        st;
      bmpr_pkg::prio_vec_type loc;
      bit                     wins;
      st = '0;
      loc = own_vector();
      case (role_now)
         bmpr_pkg::ROLE_INIT: begin
            if (ev.kind == bmpr_pkg::EV_ENABLE) begin
               role_now = bmpr_pkg::ROLE_GM;
               tick_count = '0;
               kept_gm = loc;
            end
         end
         bmpr_pkg::ROLE_GM, bmpr_pkg::ROLE_SLAVE: begin
            if (ev.kind == bmpr_pkg::EV_ANNOUNCE) begin
               // strict lexicographic compare, lower wins
               if (ev.rx.priority1 != loc.priority1)
                  wins = ev.rx.priority1 < loc.priority1;
               else if (ev.rx.clock_class != loc.clock_class)
                  wins = ev.rx.clock_class < loc.clock_class;
               else if (ev.rx.clock_accuracy != loc.clock_accuracy)
                  wins = ev.rx.clock_accuracy < loc.clock_accuracy;
               else if (ev.rx.log_variance != loc.log_variance)
                  wins = ev.rx.log_variance < loc.log_variance;
               else if (ev.rx.priority2 != loc.priority2)
                  wins = ev.rx.priority2 < loc.priority2;
               else if (ev.rx.steps_removed != loc.steps_removed)
                  wins = ev.rx.steps_removed < loc.steps_removed;
               else if (ev.rx.clock_source != loc.clock_source)
                  wins = ev.rx.clock_source < loc.clock_source;
               else
                  wins = ev.rx.identity < loc.identity;
               if (wins) begin
                  st.better = 1'b1;
                  kept_gm = ev.rx;
                  role_now = bmpr_pkg::ROLE_SLAVE;
                  tick_count = '0;
               end else begin
                  kept_gm = loc;
               end
            end else if (ev.kind == bmpr_pkg::EV_TICK) begin
               if (role_now == bmpr_pkg::ROLE_GM) begin
                  if (count_tick(interval_ticks)) begin
                     st.send = 1'b1;
                     st.seq = seq_count;
                     seq_count = seq_count + 16'd1;
                  end
               end else if (count_tick(timeout_ticks)) begin
                  role_now = bmpr_pkg::ROLE_GM;
                  tick_count = '0;
               end
            end
         end
         default: ;
      endcase
      st.role = role_now;
      st.gm = kept_gm;
      return st;
   endfunction

   function automatic port_event_type random_event();
      port_event_type ev;
      logic [159:0]   noise;
      logic [63:0]    step;
      int             pick;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      ev.rx = noise[135:0];
      pick = $urandom_range(0, 99);
      if (pick < 55)
         ev.kind = bmpr_pkg::EV_TICK;
      else if (pick < 88)
         ev.kind = bmpr_pkg::EV_ANNOUNCE;
      else if (pick < 94)
         ev.kind = bmpr_pkg::EV_ENABLE;
      else
         ev.kind = EV_UNUSED;
      // most announces sit one step off the local vector in one field
      if (ev.kind == bmpr_pkg::EV_ANNOUNCE && pick < 82) begin
         ev.rx = own_vector();
         step = ($urandom_range(0, 1) != 0) ? 64'd1 : '1;
         case ($urandom_range(0, 8))
            0: ev.rx.priority1      = ev.rx.priority1 + step[7:0];
            1: ev.rx.clock_class    = ev.rx.clock_class + step[7:0];
            2: ev.rx.clock_accuracy = ev.rx.clock_accuracy + step[7:0];
            3: ev.rx.log_variance   = ev.rx.log_variance + step[15:0];
            4: ev.rx.priority2      = ev.rx.priority2 + step[7:0];
            5: ev.rx.steps_removed  = ev.rx.steps_removed + step[15:0];
            6: ev.rx.clock_source   = ev.rx.clock_source + step[7:0];
            7: ev.rx.identity       = ev.rx.identity + step;
            default: ;
         endcase
      end
      return ev;
   endfunction

   function automatic logic [15:0] pick_ticks(int short_max);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 16'd0;
      if (r == 1)
         return 16'($urandom_range(1, 65535));
      return 16'($urandom_range(1, short_max));
   endfunction

   function automatic void add_event(logic [1:0] kind, bmpr_pkg::prio_vec_type rx);
      script_row_type row;
      row = '{what: ROW_EVENT, ev: '{kind, rx}, index: '0, data: '0, typed: 1'b0,
              role: bmpr_pkg::ROLE_INIT, send: 1'b0, seq: '0, better: 1'b0};
      script.push_back(row);
   endfunction

   function automatic void add_typed(logic [1:0] kind, bmpr_pkg::prio_vec_type rx,
                                     bmpr_pkg::role_type role, logic send,
                                     logic [15:0] seq, logic better);
      script_row_type row;
      row = '{what: ROW_EVENT, ev: '{kind, rx}, index: '0, data: '0, typed: 1'b1,
              role: role, send: send, seq: seq, better: better};
      script.push_back(row);
   endfunction

   function automatic void add_write(logic [2:0] index, logic [63:0] data);
      script_row_type row;
      row = '{what: ROW_WRITE, ev: '0, index: index, data: data, typed: 1'b0,
              role: bmpr_pkg::ROLE_INIT, send: 1'b0, seq: '0, better: 1'b0};
      script.push_back(row);
   endfunction

   task automatic write_csr(logic [2:0] index, logic [63:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         bmpr_pkg::CSR_PRIORITY1:    own_p1 = data[7:0];
         bmpr_pkg::CSR_CLOCK_CLASS:  own_class = data[7:0];
         bmpr_pkg::CSR_ACCURACY:     own_acc = data[7:0];
         bmpr_pkg::CSR_LOG_VARIANCE: own_var = data[15:0];
         bmpr_pkg::CSR_PRIORITY2:    own_p2 = data[7:0];
         bmpr_pkg::CSR_IDENTITY:     own_id = data;
         bmpr_pkg::CSR_INTERVAL:     interval_ticks = data[15:0];
         bmpr_pkg::CSR_TIMEOUT:      timeout_ticks = data[15:0];
         default: ;
      endcase
   endtask

   // holds the word until taken, then predicts its result
   task automatic send_word(port_event_type ev, output port_status_type st);
      req_valid <= 1'b1;
      req_event_kind <= ev.kind;
      req_rx_priority1 <= ev.rx.priority1;
      req_rx_clock_class <= ev.rx.clock_class;
      req_rx_clock_accuracy <= ev.rx.clock_accuracy;
      req_rx_log_variance <= ev.rx.log_variance;
      req_rx_priority2 <= ev.rx.priority2;
      req_rx_steps_removed <= ev.rx.steps_removed;
      req_rx_clock_source <= ev.rx.clock_source;
      req_rx_identity <= ev.rx.identity;
      do @(posedge clock); while (req_stall);
      st = next_port_status(ev);
   endtask

   task automatic idle_gap();
      if (!no_idle && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // receiver: random stalls plus one long hold-off to back the block up
   initial begin : rsp_side
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && results_seen >= 700) begin
            held = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(0, 99) < 6);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_status.size() == 0) begin
            $display("%0t: result word with nothing expected, role %0d", $time,
                     rsp_port_role);
            fail_count++;
         end else begin
            oldest = pending_status.pop_front();
            check_field("port_role", 64'(oldest.role), 64'(rsp_port_role));
            check_field("send_announce", 64'(oldest.send), 64'(rsp_send_announce));
            check_field("announce_sequence", 64'(oldest.seq), 64'(rsp_announce_sequence));
            check_field("better_found", 64'(oldest.better), 64'(rsp_better_found));
            check_field("gm_priority1", 64'(oldest.gm.priority1), 64'(rsp_gm_priority1));
            check_field("gm_clock_class", 64'(oldest.gm.clock_class),
                        64'(rsp_gm_clock_class));
            check_field("gm_clock_accuracy", 64'(oldest.gm.clock_accuracy),
                        64'(rsp_gm_clock_accuracy));
            check_field("gm_log_variance", 64'(oldest.gm.log_variance),
                        64'(rsp_gm_log_variance));
            check_field("gm_priority2", 64'(oldest.gm.priority2), 64'(rsp_gm_priority2));
            check_field("gm_steps_removed", 64'(oldest.gm.steps_removed),
                        64'(rsp_gm_steps_removed));
            check_field("gm_clock_source", 64'(oldest.gm.clock_source),
                        64'(rsp_gm_clock_source));
            check_field("gm_identity", oldest.gm.identity, rsp_gm_identity);
         end
      end
   end

   initial begin : stimulus
      port_status_type        st;
      bmpr_pkg::prio_vec_type zero_vec, ones_vec, home_vec, near_vec, v;
      logic [159:0]           noise;
      fail_count = 0;
      results_seen = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_event_kind = bmpr_pkg::EV_ENABLE;
      req_rx_priority1 = '0;
      req_rx_clock_class = '0;
      req_rx_clock_accuracy = '0;
      req_rx_log_variance = '0;
      req_rx_priority2 = '0;
      req_rx_steps_removed = '0;
      req_rx_clock_source = '0;
      req_rx_identity = '0;
      csr_we = 1'b0;
      csr_index = bmpr_pkg::CSR_PRIORITY1;
      csr_wdata = '0;

      own_p1 = 8'd246;
      own_class = 8'd248;
      own_acc = 8'd254;
      own_var = 16'd16640;
      own_p2 = 8'd248;
      own_id = '0;
      interval_ticks = 16'd1000;
      timeout_ticks = 16'd3000;
      role_now = bmpr_pkg::ROLE_INIT;
      tick_count = '0;
      seq_count = '0;
      kept_gm = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      zero_vec = '0;
      ones_vec = '1;
      home_vec = own_vector();
      near_vec = home_vec;
      near_vec.clock_source = bmpr_pkg::OWN_CLOCK_SOURCE - 8'd1;

      // init ignores all but enable
      add_typed(bmpr_pkg::EV_TICK, zero_vec, bmpr_pkg::ROLE_INIT, 1'b0, 16'd0, 1'b0);
      add_typed(bmpr_pkg::EV_ANNOUNCE, zero_vec, bmpr_pkg::ROLE_INIT, 1'b0, 16'd0, 1'b0);
      add_typed(EV_UNUSED, ones_vec, bmpr_pkg::ROLE_INIT, 1'b0, 16'd0, 1'b0);
      add_typed(bmpr_pkg::EV_ENABLE, zero_vec, bmpr_pkg::ROLE_GM, 1'b0, 16'd0, 1'b0);
      add_typed(bmpr_pkg::EV_ENABLE, ones_vec, bmpr_pkg::ROLE_GM, 1'b0, 16'd0, 1'b0);
      add_typed(EV_UNUSED, zero_vec, bmpr_pkg::ROLE_GM, 1'b0, 16'd0, 1'b0);
      add_typed(bmpr_pkg::EV_ANNOUNCE, ones_vec, bmpr_pkg::ROLE_GM, 1'b0, 16'd0, 1'b0);
      // a tie is not better
      add_typed(bmpr_pkg::EV_ANNOUNCE, home_vec, bmpr_pkg::ROLE_GM, 1'b0, 16'd0, 1'b0);
      add_typed(bmpr_pkg::EV_ANNOUNCE, near_vec, bmpr_pkg::ROLE_SLAVE, 1'b0, 16'd0, 1'b1);
      add_event(bmpr_pkg::EV_TICK, ones_vec);
      add_typed(bmpr_pkg::EV_ANNOUNCE, zero_vec, bmpr_pkg::ROLE_SLAVE, 1'b0, 16'd0, 1'b1);
      add_typed(bmpr_pkg::EV_ANNOUNCE, ones_vec, bmpr_pkg::ROLE_SLAVE, 1'b0, 16'd0, 1'b0);
      add_write(bmpr_pkg::CSR_INTERVAL, 64'd0);
      add_write(bmpr_pkg::CSR_TIMEOUT, 64'd0);
      add_typed(bmpr_pkg::EV_TICK, zero_vec, bmpr_pkg::ROLE_GM, 1'b0, 16'd0, 1'b0);
      add_typed(bmpr_pkg::EV_TICK, zero_vec, bmpr_pkg::ROLE_GM, 1'b1, 16'd0, 1'b0);
      add_typed(bmpr_pkg::EV_TICK, ones_vec, bmpr_pkg::ROLE_GM, 1'b1, 16'd1, 1'b0);
      add_typed(bmpr_pkg::EV_ANNOUNCE, zero_vec, bmpr_pkg::ROLE_SLAVE, 1'b0, 16'd0, 1'b1);
      add_write(bmpr_pkg::CSR_INTERVAL, 64'd2);
      add_write(bmpr_pkg::CSR_TIMEOUT, 64'd3);
      add_event(bmpr_pkg::EV_TICK, zero_vec);
      add_event(bmpr_pkg::EV_ANNOUNCE, zero_vec);
      add_event(bmpr_pkg::EV_TICK, zero_vec);
      add_event(bmpr_pkg::EV_TICK, zero_vec);
      add_typed(bmpr_pkg::EV_TICK, zero_vec, bmpr_pkg::ROLE_GM, 1'b0, 16'd0, 1'b0);
      add_event(bmpr_pkg::EV_TICK, zero_vec);
      add_typed(bmpr_pkg::EV_TICK, zero_vec, bmpr_pkg::ROLE_GM, 1'b1, 16'd2, 1'b0);
      // count past a lowered interval, then the next tick fires
      add_write(bmpr_pkg::CSR_INTERVAL, 64'd65535);
      add_event(bmpr_pkg::EV_TICK, zero_vec);
      add_event(bmpr_pkg::EV_TICK, zero_vec);
      add_event(bmpr_pkg::EV_TICK, zero_vec);
      add_write(bmpr_pkg::CSR_INTERVAL, 64'd2);
      add_typed(bmpr_pkg::EV_TICK, zero_vec, bmpr_pkg::ROLE_GM, 1'b1, 16'd3, 1'b0);

      foreach (script[i]) begin
         if (script[i].what == ROW_WRITE) begin
            drain();
            write_csr(script[i].index, script[i].data);
            csr_we <= 1'b0;
         end else begin
            send_word(script[i].ev, st);
            if (script[i].typed) begin
               st.role = script[i].role;
               st.send = script[i].send;
               st.seq = script[i].seq;
               st.better = script[i].better;
            end
            pending_status.push_back(st);
            idle_gap();
         end
      end

      for (int p = 0; p < 10; p++) begin
         drain();
         noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
         if (p == 0) begin
            v = '0;
            write_csr(bmpr_pkg::CSR_INTERVAL, 64'd1);
            write_csr(bmpr_pkg::CSR_TIMEOUT, 64'd1);
         end else if (p == 1) begin
            v = '1;
            write_csr(bmpr_pkg::CSR_INTERVAL, 64'd65535);
            write_csr(bmpr_pkg::CSR_TIMEOUT, 64'd65535);
         end else begin
            v = noise[135:0];
            write_csr(bmpr_pkg::CSR_INTERVAL, 64'(pick_ticks(6)));
            write_csr(bmpr_pkg::CSR_TIMEOUT, 64'(pick_ticks(8)));
         end
         write_csr(bmpr_pkg::CSR_PRIORITY1, 64'(v.priority1));
         write_csr(bmpr_pkg::CSR_CLOCK_CLASS, 64'(v.clock_class));
         write_csr(bmpr_pkg::CSR_ACCURACY, 64'(v.clock_accuracy));
         write_csr(bmpr_pkg::CSR_LOG_VARIANCE, 64'(v.log_variance));
         write_csr(bmpr_pkg::CSR_PRIORITY2, 64'(v.priority2));
         write_csr(bmpr_pkg::CSR_IDENTITY, v.identity);
         csr_we <= 1'b0;
         no_idle = (p == 3);
         for (int n = 0; n < 195; n++) begin
            send_word(random_event(), st);
            pending_status.push_back(st);
            idle_gap();
         end
      end

      drain();
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
